### rtl/core/bmsrx_pkg.sv
// Package for the battery response frame receiver.
// Holds the parser phase enum, the completion status codes and item structs.
// No dependencies.
package bmsrx_pkg;

  // Framing bytes
  localparam logic [7:0] START_BYTE = 8'hDD;
  localparam logic [7:0] END_BYTE   = 8'h77;
  localparam int         ERROR_BIT  = 7;   // status byte bit flagging a device error

  // Input function codes
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  // Completion status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DEV_ERR = 3'd1;
  localparam logic [2:0] ST_BAD_END = 3'd2;
  localparam logic [2:0] ST_BAD_SUM = 3'd3;
  localparam logic [2:0] ST_BAD_ALL = 3'd4;

  // Parser phases
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_CMD     = 4'd1,
    PH_STATUS  = 4'd2,
    PH_LEN     = 4'd3,
    PH_PAYLOAD = 4'd4,
    PH_SUM_HI  = 4'd5,
    PH_SUM_LO  = 4'd6,
    PH_END     = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

  // One input item
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] command_code;
    logic [2:0] frame_status;
    logic       last;
  } res_t;

endpackage

### rtl/core/bmsrx_if.sv
// Valid/ready channel interfaces for the receiver's input and result items.
// Stand-alone; field widths follow the item definitions in bmsrx_pkg.
interface bmsrx_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface bmsrx_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] command_code;
  logic [2:0] frame_status;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output command_code, output frame_status, output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_index,
                  input command_code, input frame_status, input last, output ready);
endinterface

### rtl/core/bms_response_frame_receiver.sv
// Battery response frame receiver: input register, frame parser, result register.
// A result passes through the input register and then the result register.
// Throughput: one item per cycle unless the output channel stalls.
// Reset (synchronous, active low): parser returns to start-byte hunt, all state zero,
// both stage registers empty.
module bms_response_frame_receiver
  import bmsrx_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  bmsrx_in_if.sink    in_ch,
  bmsrx_out_if.source out_ch
);

  item_t  in_item, s1_item;
  logic   s1_valid, adv, free, res_valid, out_valid;
  res_t   res, out_res;
  phase_t phase;

  assign in_item.func    = in_ch.func;
  assign in_item.rx_byte = in_ch.rx_byte;

  // held item moves on whenever the result register can take its result
  assign adv = s1_valid && free;

  bmsrx_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  bmsrx_parser u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res),
    .phase     (phase)
  );

  bmsrx_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && res_valid),
    .res_in    (res),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .free      (free),
    .res_out   (out_res)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.kind          = out_res.kind;
  assign out_ch.payload_byte  = out_res.payload_byte;
  assign out_ch.payload_index = out_res.payload_index;
  assign out_ch.command_code  = out_res.command_code;
  assign out_ch.frame_status  = out_res.frame_status;
  assign out_ch.last          = out_res.last;

  // restart always rearms the hunt
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item.func == FUNC_RESTART |=> phase == PH_HUNT)
    else $error("restart did not return parser to hunt");

  // a finished frame stays finished until restart
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item.func == FUNC_BYTE && phase == PH_DONE |=> phase == PH_DONE)
    else $error("parser left done without restart");

  // payload items carry no status and no last flag
  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.kind == KIND_PAYLOAD |-> out_res.frame_status == ST_OK && !out_res.last)
    else $error("payload item with status or last set");

  // a result is only formed in payload or end phase
  a_res_phase: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_valid |-> phase == PH_PAYLOAD || phase == PH_END)
    else $error("result formed outside payload or end phase");

endmodule

### rtl/core/bmsrx_in_stage.sv
// Input register stage of the receiver.
// Captures one item per cycle while the register is empty or its held item is consumed; depends on bmsrx_pkg.
module bmsrx_in_stage
  import bmsrx_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  adv,       // held item is consumed this cycle
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || adv;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : valid_r);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

### rtl/core/bmsrx_parser.sv
// Frame parser: phase state machine, checksum tracking and result forming.
// State advances once per consumed item; depends on bmsrx_pkg.
module bmsrx_parser
  import bmsrx_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  item_t  item,
  output logic   res_valid,
  output res_t   res,
  output phase_t phase
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic        dev_err_r, dev_err_nxt;
  logic [15:0] exp_sum_r, exp_sum_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  sum_hi_r, sum_hi_nxt;
  logic [7:0]  sum_lo_r, sum_lo_nxt;
  logic [7:0]  c;
  logic        bad_end, bad_sum;

  assign c       = item.rx_byte;
  assign bad_end = (c != END_BYTE);
  assign bad_sum = ({sum_hi_r, sum_lo_r} != exp_sum_r);

  // next state and result
  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    dev_err_nxt = dev_err_r;
    exp_sum_nxt = exp_sum_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    sum_hi_nxt  = sum_hi_r;
    sum_lo_nxt  = sum_lo_r;
    res_valid   = 1'b0;
    res         = '0;
    res.command_code = cmd_r;
    if (item.func == FUNC_RESTART) begin
      phase_nxt = PH_HUNT;
    end else begin
      case (phase_r)
        PH_HUNT: begin
          if (c == START_BYTE) phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          cmd_nxt   = c;
          phase_nxt = PH_STATUS;
        end
        PH_STATUS: begin
          dev_err_nxt = c[ERROR_BIT];
          exp_sum_nxt = 16'd0 - {8'd0, c};
          phase_nxt   = PH_LEN;
        end
        PH_LEN: begin
          len_nxt     = c;
          cnt_nxt     = 8'd0;
          exp_sum_nxt = exp_sum_r - {8'd0, c};
          phase_nxt   = (c == 8'd0) ? PH_SUM_HI : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          res_valid         = 1'b1;
          res.kind          = KIND_PAYLOAD;
          res.payload_byte  = c;
          res.payload_index = cnt_r;
          res.frame_status  = ST_OK;
          exp_sum_nxt       = exp_sum_r - {8'd0, c};
          cnt_nxt           = cnt_r + 8'd1;
          if (cnt_nxt >= len_r) phase_nxt = PH_SUM_HI;
        end
        PH_SUM_HI: begin
          sum_hi_nxt = c;
          phase_nxt  = PH_SUM_LO;
        end
        PH_SUM_LO: begin
          sum_lo_nxt = c;
          phase_nxt  = PH_END;
        end
        PH_END: begin
          res_valid         = 1'b1;
          res.kind          = KIND_DONE;
          res.payload_index = len_r;
          res.last          = 1'b1;
          // device error wins over framing faults
          if (dev_err_r)              res.frame_status = ST_DEV_ERR;
          else if (bad_end && bad_sum) res.frame_status = ST_BAD_ALL;
          else if (bad_sum)           res.frame_status = ST_BAD_SUM;
          else if (bad_end)           res.frame_status = ST_BAD_END;
          else                        res.frame_status = ST_OK;
          phase_nxt = PH_DONE;
        end
        default: begin
          // done: bytes ignored until restart
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      cmd_r     <= 8'd0;
      dev_err_r <= 1'b0;
      exp_sum_r <= 16'd0;
      len_r     <= 8'd0;
      cnt_r     <= 8'd0;
      sum_hi_r  <= 8'd0;
      sum_lo_r  <= 8'd0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      cmd_r     <= cmd_nxt;
      dev_err_r <= dev_err_nxt;
      exp_sum_r <= exp_sum_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      sum_hi_r  <= sum_hi_nxt;
      sum_lo_r  <= sum_lo_nxt;
    end
  end

  assign phase = phase_r;

endmodule

### rtl/core/bmsrx_out_reg.sv
// Result register of the receiver, holding one item for the output channel.
// Depends on bmsrx_pkg.
module bmsrx_out_reg
  import bmsrx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  input  logic out_ready,
  output logic out_valid,
  output logic free,       // register can take a new item this cycle
  output res_t res_out
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule
